@@ rtl/rpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpc_pkg
// types, codes and constants shared by the pwm pulse capture modules
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int TIME_W     = 16;
    localparam int PIN_W      = 8;
    localparam int CH_FIELD_W = 3;
    localparam int STATUS_W   = 2;
    localparam int ACTIVE_W   = 4;
    localparam int DEADBAND_W = 15;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET   = 4'd8;
    localparam logic [TIME_W-1:0]     WIDTH_MIN_RESET = 16'd920;
    localparam logic [TIME_W-1:0]     WIDTH_MAX_RESET = 16'd2120;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 15'd0;

    typedef enum logic [STATUS_W-1:0] {
        ST_RISE     = 2'd0,
        ST_WINDOW   = 2'd1,
        ST_DEADBAND = 2'd2,
        ST_UPDATED  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_CHANNELS = 3'd0,
        REG_WIDTH_MINIMUM   = 3'd1,
        REG_WIDTH_MAXIMUM   = 3'd2,
        REG_DEADBAND        = 3'd3,
        REG_AVERAGE_ENABLE  = 3'd4
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic emit_rise;
        logic start_fall;
        logic filter;
        logic emit_fall;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pending_any;
        logic cur_rise;
        logic out_free;
    } sts_t;

    function automatic logic [CH_FIELD_W-1:0] lowest_index(input logic [PIN_W-1:0] mask);
        logic [CH_FIELD_W-1:0] idx;
        idx = '0;
        for (int i = PIN_W - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = CH_FIELD_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/rpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpc_ctrl
// sequencer: takes an item, walks changed channels, runs the fall steps
// ----------------------------------------------------------------------------
module rpc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rpc_pkg::sts_t sts,
    output rpc_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PICK   = 5'b00010,
        S_WIDTH  = 5'b00100,
        S_FILTER = 5'b01000,
        S_SPARE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_PICK;
                end
            end
            S_PICK:
            begin
                if (!sts.pending_any)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.cur_rise)
                begin
                    cmd.emit_rise = sts.out_free;
                end
                else
                begin
                    cmd.start_fall = 1'b1;
                    state_next     = S_WIDTH;
                end
            end
            S_WIDTH:
            begin
                cmd.filter = 1'b1;
                state_next = S_FILTER;
            end
            S_FILTER:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_fall = 1'b1;
                    state_next    = S_PICK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/rpc_dp.sv @@
// ----------------------------------------------------------------------------
// rpc_dp
// datapath: config registers, per channel stores, width filter, output stage
// ----------------------------------------------------------------------------
module rpc_dp
#(
    parameter int CHANNELS = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [rpc_pkg::TIME_W-1:0]         in_timestamp,
    input  logic [rpc_pkg::PIN_W-1:0]          in_pins,
    input  rpc_pkg::cmd_t                      cmd,
    output rpc_pkg::sts_t                      sts,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rpc_pkg::OUT_DATA_W-1:0]     out_data,
    output logic                               out_last
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PAD_W = rpc_pkg::OUT_DATA_W - rpc_pkg::CH_FIELD_W - rpc_pkg::STATUS_W
                           - rpc_pkg::TIME_W;

    logic [rpc_pkg::ACTIVE_W-1:0]   active_reg;
    logic [rpc_pkg::TIME_W-1:0]     wmin_reg;
    logic [rpc_pkg::TIME_W-1:0]     wmax_reg;
    logic [rpc_pkg::DEADBAND_W-1:0] deadband_reg;
    logic                           avg_reg;

    logic [rpc_pkg::PIN_W-1:0]      prev_pins_reg;
    logic [rpc_pkg::PIN_W-1:0]      pending_reg;
    logic [rpc_pkg::PIN_W-1:0]      pending_next;
    logic [rpc_pkg::PIN_W-1:0]      pins_reg;
    logic [rpc_pkg::TIME_W-1:0]     now_reg;
    logic [rpc_pkg::TIME_W-1:0]     rise_reg [CHANNELS];
    logic [rpc_pkg::TIME_W-1:0]     cap_reg  [CHANNELS];

    logic [CH_W-1:0]                ch_reg;
    logic [rpc_pkg::TIME_W-1:0]     width_reg;
    logic [rpc_pkg::TIME_W-1:0]     old_reg;
    logic [rpc_pkg::TIME_W-1:0]     cand_reg;
    logic                           win_ok_reg;

    logic                           out_valid_reg;
    logic [rpc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                           out_last_reg;

    logic [rpc_pkg::PIN_W-1:0]      active_mask;
    logic [rpc_pkg::CH_FIELD_W-1:0] cur_ch;
    logic [CH_W-1:0]                sel;
    logic [rpc_pkg::PIN_W-1:0]      low_bit;
    logic                           last_now;
    logic [rpc_pkg::TIME_W:0]       sum_w;
    logic signed [rpc_pkg::TIME_W:0] diff;
    logic signed [rpc_pkg::TIME_W:0] band;
    logic                           in_band;
    rpc_pkg::status_t               fall_status;
    logic                           out_free;
    logic                           out_load;

    always_comb
    begin
        for (int i = 0; i < rpc_pkg::PIN_W; i++)
        begin
            active_mask[i] = (i < CHANNELS) && (rpc_pkg::ACTIVE_W'(i) < active_reg);
        end
    end

    assign cur_ch   = rpc_pkg::lowest_index(pending_reg);
    assign sel      = cur_ch[CH_W-1:0];
    assign low_bit  = pending_reg & (~pending_reg + rpc_pkg::PIN_W'(1));
    assign last_now = (pending_reg & ~low_bit) == '0;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = cmd.emit_rise || cmd.emit_fall;

    assign sts.pending_any = pending_reg != '0;
    assign sts.cur_rise    = pins_reg[cur_ch];
    assign sts.out_free    = out_free;

    assign sum_w = {1'b0, width_reg} + {1'b0, old_reg};
    assign diff  = $signed({1'b0, old_reg}) - $signed({1'b0, cand_reg});
    assign band  = $signed({2'b00, deadband_reg});
    assign in_band = (deadband_reg != '0) && (diff <= band) && (diff >= -band);

    always_comb
    begin
        if (!win_ok_reg)
        begin
            fall_status = rpc_pkg::ST_WINDOW;
        end
        else if (in_band)
        begin
            fall_status = rpc_pkg::ST_DEADBAND;
        end
        else
        begin
            fall_status = rpc_pkg::ST_UPDATED;
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (cmd.load_item)
        begin
            pending_next = (in_pins ^ prev_pins_reg) & active_mask;
        end
        else if (out_load)
        begin
            pending_next = pending_reg & ~low_bit;
        end
    end

    // config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= rpc_pkg::ACTIVE_RESET;
            wmin_reg      <= rpc_pkg::WIDTH_MIN_RESET;
            wmax_reg      <= rpc_pkg::WIDTH_MAX_RESET;
            deadband_reg  <= rpc_pkg::DEADBAND_RESET;
            avg_reg       <= 1'b0;
            prev_pins_reg <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                rise_reg[i] <= '0;
                cap_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    rpc_pkg::REG_ACTIVE_CHANNELS: active_reg <= cfg_data[rpc_pkg::ACTIVE_W-1:0];
                    rpc_pkg::REG_WIDTH_MINIMUM:   wmin_reg <= cfg_data[rpc_pkg::TIME_W-1:0];
                    rpc_pkg::REG_WIDTH_MAXIMUM:   wmax_reg <= cfg_data[rpc_pkg::TIME_W-1:0];
                    rpc_pkg::REG_DEADBAND:
                        deadband_reg <= cfg_data[rpc_pkg::DEADBAND_W-1:0];
                    rpc_pkg::REG_AVERAGE_ENABLE:  avg_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load_item)
            begin
                prev_pins_reg <= in_pins;
            end
            pending_reg <= pending_next;
            if (cmd.emit_rise)
            begin
                rise_reg[sel] <= now_reg;
            end
            if (cmd.emit_fall && (fall_status == rpc_pkg::ST_UPDATED))
            begin
                cap_reg[ch_reg] <= cand_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            now_reg  <= in_timestamp;
            pins_reg <= in_pins;
        end
        if (cmd.start_fall)
        begin
            ch_reg    <= sel;
            width_reg <= now_reg - rise_reg[sel];
            old_reg   <= cap_reg[sel];
        end
        if (cmd.filter)
        begin
            win_ok_reg <= (width_reg >= wmin_reg) && (width_reg <= wmax_reg);
            cand_reg   <= avg_reg ? sum_w[rpc_pkg::TIME_W:1] : width_reg;
        end
        if (cmd.emit_rise)
        begin
            out_data_reg <= {PAD_W'(0), cap_reg[sel], rpc_pkg::ST_RISE, cur_ch};
            out_last_reg <= last_now;
        end
        else if (cmd.emit_fall)
        begin
            out_data_reg <= {PAD_W'(0),
                             (fall_status == rpc_pkg::ST_UPDATED) ? cand_reg : old_reg,
                             fall_status, cur_ch};
            out_last_reg <= last_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/rc_pwm_pulse_capture_unit.sv @@
// ----------------------------------------------------------------------------
// rc_pwm_pulse_capture_unit
// servo pwm input capture: pulse widths from timestamped pin samples
// ----------------------------------------------------------------------------
// slave stream: one item per pin sample, tdata = timestamp, pin levels.
// master stream: one item per handled channel, tdata = channel, status,
// captured width; tlast marks the final item of a sample. a sample with no
// handled channel produces nothing.
// config channel: cfg_ready is always high, a write is registered; write
// only while the block is idle.
// sequence: a sample is taken into registers, then the sequencer walks the changed
// channels lowest first. a rising edge loads its item into the output register
// when the scan reaches it and that register is free; a falling edge goes
// through width, filter and result steps. s_axis_tready is high only between
// samples. a stalled receiver holds the output register and the scan waits on it.
// reset clears config to defaults, previous pins, rise times and captures.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_capture_unit
#(
    parameter int CHANNELS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rpc_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // timestamp[15:0], pin_levels[23:16]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // channel[2:0], status[4:3],
                                                           // captured_width[20:5], zero[23:21]
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_data
);

    rpc_pkg::cmd_t cmd;
    rpc_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    rpc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpc_dp
    #(
        .CHANNELS (CHANNELS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_timestamp (s_axis_tdata[rpc_pkg::TIME_W-1:0]),
        .in_pins      (s_axis_tdata[rpc_pkg::TIME_W +: rpc_pkg::PIN_W]),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_last     (m_axis_tlast)
    );

endmodule

@@ rtl/rpc_checker.sv @@
// ----------------------------------------------------------------------------
// rpc_checker
// port level checks for the pwm pulse capture unit
// ----------------------------------------------------------------------------
module rpc_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    // only the final item of a sample may still wait while a new one is taken
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("non-final item pending while input ready");

    // one sample at a time
    a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // a sample taken with the output empty never raises a result by itself
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result without scan step");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed under stall");

endmodule

bind rc_pwm_pulse_capture_unit rpc_checker u_rpc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/rc_pwm_pulse_capture_unit_tb.sv @@
// ----------------------------------------------------------------------------
// rc_pwm_pulse_capture_unit_tb
// self-checking bench for the servo pwm pulse capture unit
// ----------------------------------------------------------------------------
// pin samples go in on the slave stream while an independent pulse tracker
// in the bench follows rise times, captures and settings and queues the
// expected capture items. each item on the master stream is compared with
// the oldest queued one. a short scripted part walks the edge cases first;
// random phases with different settings follow, mostly clean servo pulses,
// with multi-pin changes, unchanged samples and noise mixed in. both
// streams stall at random except in one steady phase.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_capture_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 36;

    typedef struct packed {
        logic [2:0]        channel;
        rpc_pkg::status_t  status;
        logic [15:0]       width;
        logic              last;
    } capture_item_t;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_CHECKED,
        ROW_SETUP
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [15:0]       stamp;
        logic [7:0]        pins;
        logic [2:0]        channel;
        rpc_pkg::status_t  status;
        logic [15:0]       width;
        logic [3:0]        lanes;
        logic [15:0]       lo;
        logic [15:0]       hi;
        logic [14:0]       band;
        logic              smooth;
    } script_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [rpc_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [rpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rpc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [rpc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // pulse tracker state and its copy of the settings
    logic [3:0]     lane_count = rpc_pkg::ACTIVE_RESET;
    logic [15:0]    win_lo = rpc_pkg::WIDTH_MIN_RESET;
    logic [15:0]    win_hi = rpc_pkg::WIDTH_MAX_RESET;
    logic [14:0]    jitter_band = rpc_pkg::DEADBAND_RESET;
    logic           smooth_on = 1'b0;
    logic [7:0]     pin_history = '0;
    logic [15:0]    rise_stamp [8];
    logic [15:0]    pulse_store [8];

    capture_item_t  expected_q [$];
    capture_item_t  due;
    script_row_t    script [$];
    int             err_count = 0;
    int             cycle_count = 0;
    bit             steady = 1'b0;

    rc_pwm_pulse_capture_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    task automatic report_mismatch(input string what);
        if (err_count < 40)
        begin
            $display("MISMATCH @%0t: %s", $realtime, what);
        end
        err_count++;
    endtask

    // expected capture items for one pin sample, tracker state updated
    function automatic int predict_edges(input logic [15:0] stamp, input logic [7:0] pins);
        logic [7:0]        flips;
        logic [15:0]       w;
        logic [16:0]       total;
        int                lanes;
        int                n;
        int                diff;
        int                band;
        int                old_cap;
        rpc_pkg::status_t  st;
        capture_item_t     batch [8];
        flips = pins ^ pin_history;
        n = 0;
        if (flips == '0)
        begin
            return 0;
        end
        lanes = (lane_count > 8) ? 8 : int'(lane_count);
        band = int'(jitter_band);
        for (int ch = 0; ch < lanes; ch++)
        begin
            if (flips[ch])
            begin
                if (pins[ch])
                begin
                    rise_stamp[ch] = stamp;
                    st = rpc_pkg::ST_RISE;
                end
                else
                begin
                    w = stamp - rise_stamp[ch];
                    if (w < win_lo || w > win_hi)
                    begin
                        st = rpc_pkg::ST_WINDOW;
                    end
                    else
                    begin
                        if (smooth_on)
                        begin
                            total = {1'b0, w} + {1'b0, pulse_store[ch]};
                            w = total[16:1];
                        end
                        old_cap = int'(pulse_store[ch]);
                        diff = old_cap - int'(w);
                        if (band != 0 && diff <= band && diff >= -band)
                        begin
                            st = rpc_pkg::ST_DEADBAND;
                        end
                        else
                        begin
                            pulse_store[ch] = w;
                            st = rpc_pkg::ST_UPDATED;
                        end
                    end
                end
                batch[n] = '{channel: 3'(ch), status: st, width: pulse_store[ch], last: 1'b0};
                n++;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            batch[i].last = (i == n - 1);
            expected_q.push_back(batch[i]);
        end
        pin_history = pins;
        return n;
    endfunction

    task automatic push_sample(input logic [15:0] stamp, input logic [7:0] pins,
                               output int produced);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        produced = predict_edges(stamp, pins);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pins, stamp};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input rpc_pkg::cfg_reg_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            rpc_pkg::REG_ACTIVE_CHANNELS: lane_count = value[3:0];
            rpc_pkg::REG_WIDTH_MINIMUM:   win_lo = value;
            rpc_pkg::REG_WIDTH_MAXIMUM:   win_hi = value;
            rpc_pkg::REG_DEADBAND:        jitter_band = value[14:0];
            rpc_pkg::REG_AVERAGE_ENABLE:  smooth_on = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [3:0] lanes, input logic [15:0] lo,
                                  input logic [15:0] hi, input logic [14:0] band,
                                  input logic smooth);
        write_register(rpc_pkg::REG_ACTIVE_CHANNELS, {12'd0, lanes});
        write_register(rpc_pkg::REG_WIDTH_MINIMUM, lo);
        write_register(rpc_pkg::REG_WIDTH_MAXIMUM, hi);
        write_register(rpc_pkg::REG_DEADBAND, {1'b0, band});
        write_register(rpc_pkg::REG_AVERAGE_ENABLE, {15'd0, smooth});
        cfg_valid <= 1'b0;
    endtask

    function automatic script_row_t sample_row(input logic [15:0] stamp,
                                               input logic [7:0] pins);
        script_row_t r;
        r = '{kind: ROW_SAMPLE, stamp: stamp, pins: pins, channel: '0,
              status: rpc_pkg::ST_RISE, width: '0, lanes: '0, lo: '0, hi: '0,
              band: '0, smooth: 1'b0};
        return r;
    endfunction

    function automatic script_row_t checked_row(input logic [15:0] stamp,
                                                input logic [7:0] pins,
                                                input logic [2:0] ch,
                                                input rpc_pkg::status_t st,
                                                input logic [15:0] width);
        script_row_t r;
        r = sample_row(stamp, pins);
        r.kind = ROW_CHECKED;
        r.channel = ch;
        r.status = st;
        r.width = width;
        return r;
    endfunction

    function automatic script_row_t setup_row(input logic [3:0] lanes, input logic [15:0] lo,
                                              input logic [15:0] hi, input logic [14:0] band,
                                              input logic smooth);
        script_row_t r;
        r = sample_row('0, '0);
        r.kind = ROW_SETUP;
        r.lanes = lanes;
        r.lo = lo;
        r.hi = hi;
        r.band = band;
        r.smooth = smooth;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item ch %0d st %0d width %0d",
                                          m_axis_tdata[2:0], m_axis_tdata[4:3],
                                          m_axis_tdata[20:5]));
            end
            else
            begin
                due = expected_q.pop_front();
                if (m_axis_tdata[2:0] != due.channel || m_axis_tdata[4:3] != due.status ||
                    m_axis_tdata[20:5] != due.width || m_axis_tlast != due.last ||
                    m_axis_tdata[23:21] != 3'd0)
                begin
                    report_mismatch($sformatf(
                        {"got ch %0d st %0d width %0d last %0b pad %0d, ",
                         "exp ch %0d st %0d width %0d last %0b"},
                        m_axis_tdata[2:0], m_axis_tdata[4:3], m_axis_tdata[20:5],
                        m_axis_tlast, m_axis_tdata[23:21],
                        due.channel, due.status, due.width, due.last));
                end
            end
        end
    end

    initial
    begin : stimulus
        script_row_t    row;
        capture_item_t  latest;
        logic [7:0]     pins;
        logic [7:0]     flip;
        logic [15:0]    clock_ts;
        int             n;
        int             roll;
        int             c;
        int             counted;
        int             nominal;

        for (int i = 0; i < 8; i++)
        begin
            rise_stamp[i] = '0;
            pulse_store[i] = '0;
        end

        // reset state, edge widths at the window limits, wrap of the timer
        script.push_back(sample_row(16'd0, 8'h00));
        script.push_back(checked_row(16'd100, 8'h01, 3'd0, rpc_pkg::ST_RISE, 16'd0));
        script.push_back(checked_row(16'd1600, 8'h00, 3'd0, rpc_pkg::ST_UPDATED, 16'd1500));
        script.push_back(sample_row(16'd2000, 8'hFF));
        script.push_back(checked_row(16'd2920, 8'hFE, 3'd0, rpc_pkg::ST_UPDATED, 16'd920));
        script.push_back(checked_row(16'd4120, 8'hFC, 3'd1, rpc_pkg::ST_UPDATED, 16'd2120));
        script.push_back(checked_row(16'd4121, 8'hF8, 3'd2, rpc_pkg::ST_WINDOW, 16'd0));
        script.push_back(checked_row(16'd2919, 8'hF0, 3'd3, rpc_pkg::ST_WINDOW, 16'd0));
        script.push_back(sample_row(16'd3500, 8'h00));
        script.push_back(checked_row(16'd65000, 8'h01, 3'd0, rpc_pkg::ST_RISE, 16'd920));
        script.push_back(checked_row(16'd464, 8'h00, 3'd0, rpc_pkg::ST_UPDATED, 16'd1000));
        // no channels, then a count above eight
        script.push_back(setup_row(4'd0, 16'd920, 16'd2120, 15'd0, 1'b0));
        script.push_back(sample_row(16'd5000, 8'hFF));
        script.push_back(setup_row(4'd15, 16'd920, 16'd2120, 15'd0, 1'b0));
        script.push_back(sample_row(16'd6500, 8'h00));
        // changes on inactive pins only, then rises on the active ones
        script.push_back(setup_row(4'd3, 16'd920, 16'd2120, 15'd0, 1'b0));
        script.push_back(sample_row(16'd7000, 8'hF8));
        script.push_back(sample_row(16'd7100, 8'hFF));
        // window with minimum above maximum
        script.push_back(setup_row(4'd1, 16'd2000, 16'd1000, 15'd0, 1'b0));
        script.push_back(checked_row(16'd8600, 8'hFE, 3'd0, rpc_pkg::ST_WINDOW, 16'd1000));
        // full window, largest width, averaging carry, widest deadband
        script.push_back(setup_row(4'd1, 16'd0, 16'd65535, 15'd0, 1'b0));
        script.push_back(checked_row(16'd10, 8'hFF, 3'd0, rpc_pkg::ST_RISE, 16'd1000));
        script.push_back(checked_row(16'd9, 8'hFE, 3'd0, rpc_pkg::ST_UPDATED, 16'd65535));
        script.push_back(setup_row(4'd1, 16'd0, 16'd65535, 15'd0, 1'b1));
        script.push_back(checked_row(16'd10, 8'hFF, 3'd0, rpc_pkg::ST_RISE, 16'd65535));
        script.push_back(checked_row(16'd9, 8'hFE, 3'd0, rpc_pkg::ST_UPDATED, 16'd65535));
        script.push_back(checked_row(16'd5, 8'hFF, 3'd0, rpc_pkg::ST_RISE, 16'd65535));
        script.push_back(checked_row(16'd5, 8'hFE, 3'd0, rpc_pkg::ST_UPDATED, 16'd32767));
        script.push_back(setup_row(4'd1, 16'd0, 16'd65535, 15'd32767, 1'b1));
        script.push_back(checked_row(16'd5, 8'hFF, 3'd0, rpc_pkg::ST_RISE, 16'd32767));
        script.push_back(checked_row(16'd5, 8'hFE, 3'd0, rpc_pkg::ST_DEADBAND, 16'd32767));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            row = script[i];
            case (row.kind)
                ROW_SETUP:
                begin
                    settle_idle();
                    apply_settings(row.lanes, row.lo, row.hi, row.band, row.smooth);
                end
                ROW_CHECKED:
                begin
                    push_sample(row.stamp, row.pins, n);
                    latest = expected_q[$];
                    if (n != 1 || latest.channel != row.channel ||
                        latest.status != row.status || latest.width != row.width)
                    begin
                        report_mismatch($sformatf(
                            "row %0d: tracker gives %0d items, ch %0d st %0d width %0d",
                            i, n, latest.channel, latest.status, latest.width));
                    end
                end
                default:
                begin
                    push_sample(row.stamp, row.pins, n);
                end
            endcase
        end

        clock_ts = 16'd20000;
        for (int phase = 0; phase < 5; phase++)
        begin
            settle_idle();
            nominal = 1500;
            case (phase)
                0: apply_settings(rpc_pkg::ACTIVE_RESET, rpc_pkg::WIDTH_MIN_RESET,
                                  rpc_pkg::WIDTH_MAX_RESET, rpc_pkg::DEADBAND_RESET, 1'b0);
                1: apply_settings(4'd8, 16'd920, 16'd2120, 15'd20, 1'b1);
                2:
                begin
                    nominal = $urandom_range(800, 2300);
                    apply_settings(4'($urandom_range(0, 15)), 16'($urandom_range(0, 1200)),
                                   16'($urandom_range(1300, 65535)),
                                   15'($urandom_range(0, 100)), 1'($urandom_range(0, 1)));
                end
                3:
                begin
                    steady = 1'b1;
                    apply_settings(4'd8, 16'd0, 16'd65535, 15'($urandom_range(0, 32767)),
                                   1'($urandom_range(0, 1)));
                end
                default: apply_settings(4'd3, 16'd1400, 16'd1600, 15'd5, 1'b1);
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                begin
                    // one servo pulse of roughly nominal width on a channel
                    c = $urandom_range(0, 7);
                    if (pin_history[c])
                    begin
                        pins = pin_history;
                        pins[c] = 1'b0;
                        clock_ts += 16'($urandom_range(200, 900));
                        push_sample(clock_ts, pins, n);
                        counted++;
                    end
                    pins = pin_history;
                    pins[c] = 1'b1;
                    clock_ts += 16'($urandom_range(200, 2000));
                    push_sample(clock_ts, pins, n);
                    pins = pin_history;
                    pins[c] = 1'b0;
                    clock_ts += 16'(nominal + $urandom_range(0, 40) - 20);
                    push_sample(clock_ts, pins, n);
                    counted += 2;
                end
                else if (roll < 72)
                begin
                    flip = 8'(1 << $urandom_range(0, 7));
                    if ($urandom_range(0, 2) == 0)
                    begin
                        flip |= 8'(1 << $urandom_range(0, 7));
                    end
                    clock_ts += 16'($urandom_range(100, 1500));
                    push_sample(clock_ts, pin_history ^ flip, n);
                    counted++;
                end
                else if (roll < 80)
                begin
                    clock_ts += 16'($urandom_range(1, 3000));
                    push_sample(clock_ts, pin_history, n);
                end
                else if (roll < 88)
                begin
                    clock_ts += 16'($urandom_range(100, 2500));
                    push_sample(clock_ts, ~pin_history, n);
                    counted++;
                end
                else
                begin
                    pins = 8'($urandom);
                    clock_ts = 16'($urandom);
                    if (pins != pin_history)
                    begin
                        counted++;
                    end
                    push_sample(clock_ts, pins, n);
                end
                if ($urandom_range(0, 99) < 2)
                begin
                    settle_idle();
                end
            end
            steady = 1'b0;
        end

        settle_idle();
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
